/* design/gbn_pkg.sv */
package gbn_pkg;

   localparam int SEQ_MAX    = 7;
   localparam int SEQ_W      = 3;
   localparam int DATA_WIDTH = 32;
   localparam int TICK_W     = 17;
   localparam int CNT_W      = 3;
   localparam int QDEPTH     = 2;

   localparam logic [1:0] ACT_RX   = 2'd0;
   localparam logic [1:0] ACT_TX   = 2'd1;
   localparam logic [1:0] ACT_TICK = 2'd2;

   localparam logic [1:0] KIND_DELIVER = 2'd0;
   localparam logic [1:0] KIND_DATA    = 2'd1;
   localparam logic [1:0] KIND_ACK     = 2'd2;
   localparam logic [1:0] KIND_REFUSE  = 2'd3;

   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   typedef struct packed {
      logic [1:0]            action;
      logic [SEQ_W-1:0]      rx_seq;
      logic [SEQ_W-1:0]      rx_ack;
      logic                  rx_final;
      logic [DATA_WIDTH-1:0] data;
      logic                  tx_final;
   } cmd_type;

   typedef struct packed {
      logic [1:0]            kind;
      logic [SEQ_W-1:0]      seq;
      logic [SEQ_W-1:0]      ack;
      logic [DATA_WIDTH-1:0] data;
      logic                  end_flag;
      logic                  sent;
      logic                  rcvd;
      logic                  last;
   } rsp_type;

   function automatic logic in_window(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b,
                                      logic [SEQ_W-1:0] c);
      return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
   endfunction

endpackage

/* design/gbn_front.sv */
module gbn_front import gbn_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [1:0]            req_action,
   input  logic [SEQ_W-1:0]      req_rx_seq,
   input  logic [SEQ_W-1:0]      req_rx_ack,
   input  logic                  req_rx_crc_ok,
   input  logic                  req_rx_final,
   input  logic [DATA_WIDTH-1:0] req_rx_data,
   input  logic [DATA_WIDTH-1:0] req_tx_data,
   input  logic                  req_tx_final,
   output logic                  cmd_valid,
   output cmd_type               cmd,
   input  logic                  cmd_take
);
   cmd_type q_ff [QDEPTH];
   logic    wp_ff, rp_ff, wp_in, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic    push_ok, keep;
   cmd_type c;

   // drop bad crc frames and unused codes here
   always_comb begin
      c.action   = req_action;
      c.rx_seq   = req_rx_seq;
      c.rx_ack   = req_rx_ack;
      c.rx_final = req_rx_final;
      c.data     = (req_action == ACT_TX) ? req_tx_data : req_rx_data;
      c.tx_final = req_tx_final;
      keep = (req_action == ACT_TX) || (req_action == ACT_TICK)
          || ((req_action == ACT_RX) && req_rx_crc_ok);
   end

   assign req_full  = (cnt_ff == 2'(QDEPTH));
   assign push_ok   = req_push && !req_full;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push_ok && keep) begin
         wp_in = ~wp_ff;
      end
      if (cmd_take && cmd_valid) begin
         rp_in = ~rp_ff;
      end
      cnt_in = cnt_ff + 2'(push_ok && keep) - 2'(cmd_take && cmd_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push_ok && keep) begin
         q_ff[wp_ff] <= c;
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'(QDEPTH))
      else $error("queue overfilled");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> (wp_ff == rp_ff))
      else $error("pointers disagree on empty");
   assert property (@(posedge clock) disable iff (reset)
      (push_ok && keep && !(cmd_take && cmd_valid)) |=> (cnt_ff == $past(cnt_ff) + 2'd1))
      else $error("count missed a beat");
endmodule

/* design/gbn_back.sv */
module gbn_back import gbn_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   input  cmd_type               cmd,
   output logic                  cmd_take,
   input  logic [15:0]           timeout_ticks,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_type               rsp
);
   typedef enum logic [2:0] {ST_IDLE, ST_SLIDE, ST_RESEND, ST_FETCH} state_type;

   state_type             state_ff;
   logic [SEQ_W-1:0]      exp_ff, nxt_ff, old_ff, ack_ff, rs_ff;
   logic [CNT_W-1:0]      out_ff, rem_ff;
   logic [TICK_W-1:0]     tick_ff;
   logic                  armed_ff, txfin_ff, sent_ff, rcvd_ff;
   logic [DATA_WIDTH-1:0] store [SEQ_MAX+1];
   logic [DATA_WIDTH-1:0] rd_ff;
   // result buffer holds two pending beats
   rsp_type               ob_ff [2];
   logic [1:0]            ocnt_ff;
   logic                  ow_ff, or_ff;
   // one deferred beat: last flag is set once the next beat (or end) is known
   rsp_type               pend_ff;
   logic                  pend_v_ff;

   logic                  room;
   logic                  slide_go;
   logic [TICK_W-1:0]     tick_nx;

   assign room      = (ocnt_ff == 2'd0) || (ocnt_ff == 2'd1 && !pend_v_ff);
   assign rsp_empty = (ocnt_ff == 2'd0);
   assign rsp       = ob_ff[or_ff];
   assign cmd_take  = (state_ff == ST_IDLE) && cmd_valid && !pend_v_ff && (ocnt_ff == 2'd0);
   assign slide_go  = (out_ff != '0) && in_window(old_ff, ack_ff, nxt_ff);
   assign tick_nx   = (tick_ff == {TICK_W{1'b1}}) ? tick_ff : tick_ff + 1'b1;

   always_ff @(posedge clock) begin
      logic    em1, em2, fin;
      rsp_type b1, b2;
      logic    popped;
      logic    sn, rn;
      em1 = 1'b0; em2 = 1'b0; fin = 1'b0;
      b1 = '0; b2 = '0;
      popped = rsp_pop && !rsp_empty;
      sn = sent_ff; rn = rcvd_ff;
      if (reset) begin
         state_ff <= ST_IDLE;
         exp_ff <= '0; nxt_ff <= '0; old_ff <= '0; out_ff <= '0;
         tick_ff <= '0; armed_ff <= 1'b0;
         txfin_ff <= 1'b0; sent_ff <= 1'b0; rcvd_ff <= 1'b0;
         ocnt_ff <= 2'd0; ow_ff <= 1'b0; or_ff <= 1'b0;
         pend_v_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (cmd_take) begin
                  case (cmd.action)
                     ACT_RX: begin
                        logic s;
                        s = sent_ff;
                        if (cmd.rx_seq == exp_ff) begin
                           if (!rcvd_ff) begin
                              em1 = 1'b1;
                              b1 = '{KIND_DELIVER, cmd.rx_seq, exp_ff - 1'b1,
                                     cmd.data, 1'b0, 1'b0, 1'b0, 1'b0};
                              if (cmd.rx_final) begin
                                 rcvd_ff <= 1'b1;
                                 rn = 1'b1;
                              end else begin
                                 exp_ff <= exp_ff + 1'b1;
                              end
                           end
                           if (s) begin
                              em2 = 1'b1;
                              b2 = '{KIND_ACK, nxt_ff,
                                     (!rcvd_ff && !cmd.rx_final) ? exp_ff : exp_ff - 1'b1,
                                     '0, 1'b1, 1'b0, 1'b0, 1'b0};
                           end
                        end
                        ack_ff <= cmd.rx_ack;
                        state_ff <= ST_SLIDE;
                     end
                     ACT_TX: begin
                        em1 = 1'b1;
                        if ((out_ff < CNT_W'(SEQ_MAX)) && !txfin_ff) begin
                           store[nxt_ff] <= cmd.data;
                           b1 = '{KIND_DATA, nxt_ff, exp_ff - 1'b1, cmd.data, 1'b0,
                                  1'b0, 1'b0, 1'b0};
                           out_ff <= out_ff + 1'b1;
                           nxt_ff <= nxt_ff + 1'b1;
                           if (!armed_ff) begin
                              armed_ff <= 1'b1;
                              tick_ff  <= '0;
                           end
                           if (cmd.tx_final) begin
                              txfin_ff <= 1'b1;
                           end
                        end else begin
                           b1 = '{KIND_REFUSE, nxt_ff, exp_ff - 1'b1, cmd.data, 1'b0,
                                  1'b0, 1'b0, 1'b0};
                        end
                        fin = 1'b1;
                     end
                     ACT_TICK: begin
                        if (armed_ff) begin
                           if ({1'b0, tick_nx} > {2'b0, timeout_ticks}) begin
                              tick_ff  <= '0;
                              rs_ff    <= old_ff;
                              rem_ff   <= out_ff;
                              nxt_ff   <= old_ff + out_ff;
                              state_ff <= (out_ff != '0) ? ST_FETCH : ST_IDLE;
                              fin      = (out_ff == '0);
                           end else begin
                              tick_ff <= tick_nx;
                              fin = 1'b1;
                           end
                        end else begin
                           fin = 1'b1;
                        end
                     end
                     default: fin = 1'b1;
                  endcase
               end
            end
            ST_SLIDE: begin
               if (room) begin
                  if (slide_go) begin
                     out_ff  <= out_ff - 1'b1;
                     tick_ff <= '0;
                     old_ff  <= old_ff + 1'b1;
                     if (out_ff == CNT_W'(1)) begin
                        armed_ff <= 1'b0;
                        if (txfin_ff && !sent_ff) begin
                           em1 = 1'b1;
                           b1 = '{KIND_ACK, nxt_ff, exp_ff - 1'b1, '0, 1'b1,
                                  1'b0, 1'b0, 1'b0};
                           sent_ff <= 1'b1;
                           sn = 1'b1;
                        end
                     end
                  end else begin
                     fin = 1'b1;
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_FETCH: begin
               rd_ff    <= store[rs_ff];
               state_ff <= ST_RESEND;
            end
            ST_RESEND: begin
               if (room) begin
                  em1 = 1'b1;
                  b1 = '{KIND_DATA, rs_ff, exp_ff - 1'b1, rd_ff, 1'b0,
                         1'b0, 1'b0, 1'b0};
                  rs_ff  <= rs_ff + 1'b1;
                  rem_ff <= rem_ff - 1'b1;
                  if (rem_ff == CNT_W'(1)) begin
                     fin = 1'b1;
                     state_ff <= ST_IDLE;
                  end else begin
                     state_ff <= ST_FETCH;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase

         // merge beats into pending slot; status stamped as each beat leaves
         begin
            rsp_type q [3];
            logic    qv [3];
            logic [1:0] n, k;
            logic [1:0] oc;
            logic       w;
            logic       pv;
            rsp_type    pd;
            q[0] = pend_ff; qv[0] = pend_v_ff;
            q[1] = b1;      qv[1] = em1;
            q[2] = b2;      qv[2] = em2;
            oc = ocnt_ff - 2'(popped);
            w  = ow_ff;
            n  = 2'd0;
            pv = 1'b0;
            pd = pend_ff;
            for (int i = 0; i < 3; i++) begin
               if (qv[i]) begin
                  n = n + 1'b1;
               end
            end
            k = 2'd0;
            for (int i = 0; i < 3; i++) begin
               if (qv[i]) begin
                  k = k + 1'b1;
                  if (k == n && !fin) begin
                     pd = q[i];
                     pv = 1'b1;
                  end else begin
                     rsp_type t;
                     t = q[i];
                     t.sent = sn;
                     t.rcvd = rn;
                     t.last = fin && (k == n);
                     ob_ff[w] <= t;
                     w  = ~w;
                     oc = oc + 1'b1;
                  end
               end
            end
            pend_ff   <= pd;
            pend_v_ff <= pv;
            ocnt_ff   <= oc;
            ow_ff     <= w;
         end
         if (popped) begin
            or_ff <= ~or_ff;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset) ocnt_ff <= 2'd2)
      else $error("result buffer overfilled");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESEND) |-> (rem_ff != '0))
      else $error("resend with nothing left");
   assert property (@(posedge clock) disable iff (reset)
      (out_ff == '0) |-> !($past(state_ff) == ST_IDLE && state_ff == ST_FETCH))
      else $error("resend of empty window");
endmodule

/* design/go_back_n_arq_endpoint.sv */
// Go-Back-N endpoint, 3-bit sequence numbers. A two-entry front queue takes one beat per cycle
// while it has room and drops bad-crc frames and the unused action code at once; an accepted
// item is registered in that queue before it is offered to the back engine. The engine runs
// one item at a time and takes the next only once every result of the previous one has been
// popped. A payload or tick is handled in the idle state; a received frame then moves to a
// slide state that retires one acked frame per step, and a timeout alternates fetch and resend
// states per resent frame, the fetch state covering the registered frame store read. Results
// leave through a 2-entry output queue; status bits carry the state after the item.
module go_back_n_arq_endpoint import gbn_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [1:0]            req_action,
   input  logic [SEQ_W-1:0]      req_rx_seq,
   input  logic [SEQ_W-1:0]      req_rx_ack,
   input  logic                  req_rx_crc_ok,
   input  logic                  req_rx_final,
   input  logic [DATA_WIDTH-1:0] req_rx_data,
   input  logic [DATA_WIDTH-1:0] req_tx_data,
   input  logic                  req_tx_final,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [1:0]            rsp_out_kind,
   output logic [SEQ_W-1:0]      rsp_out_seq,
   output logic [SEQ_W-1:0]      rsp_out_ack,
   output logic [DATA_WIDTH-1:0] rsp_out_data,
   output logic                  rsp_out_end,
   output logic                  rsp_sending_done,
   output logic                  rsp_receiving_done,
   output logic                  rsp_last_of_run,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [15:0]           csr_timeout_ticks
);
   logic        cmd_valid, cmd_take;
   cmd_type     cmd;
   rsp_type     rsp;
   logic [15:0] timeout_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_valid) begin
         timeout_ff <= csr_timeout_ticks;
      end
   end

   gbn_front u_front (
      .clock, .reset, .req_push, .req_full, .req_action, .req_rx_seq, .req_rx_ack,
      .req_rx_crc_ok, .req_rx_final, .req_rx_data, .req_tx_data, .req_tx_final,
      .cmd_valid, .cmd, .cmd_take
   );

   gbn_back u_back (
      .clock, .reset, .cmd_valid, .cmd, .cmd_take, .timeout_ticks(timeout_ff),
      .rsp_empty, .rsp_pop, .rsp
   );

   assign rsp_out_kind       = rsp.kind;
   assign rsp_out_seq        = rsp.seq;
   assign rsp_out_ack        = rsp.ack;
   assign rsp_out_data       = rsp.data;
   assign rsp_out_end        = rsp.end_flag;
   assign rsp_sending_done   = rsp.sent;
   assign rsp_receiving_done = rsp.rcvd;
   assign rsp_last_of_run    = rsp.last;
endmodule

/* sim/tb_go_back_n_arq_endpoint.sv */
module tb_go_back_n_arq_endpoint;
   import gbn_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      bit [1:0]  action;
      bit [2:0]  rx_seq;
      bit [2:0]  rx_ack;
      bit        crc_ok;
      bit        rx_final;
      bit [31:0] rx_data;
      bit [31:0] tx_data;
      bit        tx_final;
   } beat_type;

   class arq_scoreboard;
      bit [15:0] timeout;
      bit [2:0]  exp_seq, send_seq, oldest, in_flight;
      bit [16:0] ticks;
      bit        armed, tx_fin, sent, rcvd;
      bit [31:0] store [8];
      rsp_type   run [$];
      rsp_type   due [$];
      int        errors;

      function new();
         timeout = TIMEOUT_RESET;
      endfunction

      // b within the cyclic half-open range [a, c)
      function bit covers(bit [2:0] a, bit [2:0] b, bit [2:0] c);
         bit [2:0] db, dc;
         db = b - a;
         dc = c - a;
         return db < dc;
      endfunction

      function void emit(logic [1:0] kind, bit [2:0] seq, bit [31:0] data, bit end_flag);
         rsp_type r;
         r.kind = kind;
         r.seq = seq;
         r.ack = exp_seq - 3'd1;
         r.data = data;
         r.end_flag = end_flag;
         r.sent = 0;
         r.rcvd = 0;
         r.last = 0;
         run.push_back(r);
      endfunction

      function void note_beat(beat_type b);
         bit [2:0] s;
         int i;
         run.delete();
         case (b.action)
            ACT_RX: begin
               if (b.crc_ok) begin
                  if (b.rx_seq == exp_seq) begin
                     if (!rcvd) begin
                        emit(KIND_DELIVER, b.rx_seq, b.rx_data, 0);
                        if (b.rx_final) rcvd = 1;
                        else exp_seq++;
                     end
                     if (sent) emit(KIND_ACK, send_seq, 0, 1);
                  end
                  while (in_flight != 0 && covers(oldest, b.rx_ack, send_seq)) begin
                     in_flight--;
                     ticks = 0;
                     oldest++;
                     if (in_flight == 0) begin
                        armed = 0;
                        if (tx_fin && !sent) begin
                           emit(KIND_ACK, send_seq, 0, 1);
                           sent = 1;
                        end
                     end
                  end
               end
            end
            ACT_TX: begin
               if (in_flight < SEQ_MAX && !tx_fin) begin
                  store[send_seq] = b.tx_data;
                  emit(KIND_DATA, send_seq, b.tx_data, 0);
                  in_flight++;
                  send_seq++;
                  if (!armed) begin
                     armed = 1;
                     ticks = 0;
                  end
                  if (b.tx_final) tx_fin = 1;
               end else begin
                  emit(KIND_REFUSE, send_seq, b.tx_data, 0);
               end
            end
            ACT_TICK: begin
               if (armed) begin
                  if (ticks != '1) ticks++;
                  if (ticks > timeout) begin
                     s = oldest;
                     for (i = 0; i < in_flight; i++) begin
                        emit(KIND_DATA, s, store[s], 0);
                        s++;
                     end
                     send_seq = s;
                     ticks = 0;
                  end
               end
            end
            default: ;
         endcase
         foreach (run[k]) begin
            run[k].sent = sent;
            run[k].rcvd = rcvd;
            run[k].last = (k == run.size() - 1);
            due.push_back(run[k]);
         end
      endfunction

      task report(string what, longint e, longint g);
         $display("%0t mismatch %s: expected %0h got %0h", $realtime, what, e, g);
         errors++;
      endtask

      task check_rsp(rsp_type got);
         rsp_type e;
         if (due.size() == 0) begin
            report("unexpected beat", 0, got.kind);
            return;
         end
         e = due.pop_front();
         if (got.kind !== e.kind) report("kind", e.kind, got.kind);
         if (got.seq !== e.seq) report("seq", e.seq, got.seq);
         if (got.ack !== e.ack) report("ack", e.ack, got.ack);
         if (got.data !== e.data) report("data", e.data, got.data);
         if (got.end_flag !== e.end_flag) report("end", e.end_flag, got.end_flag);
         if (got.sent !== e.sent) report("sending_done", e.sent, got.sent);
         if (got.rcvd !== e.rcvd) report("receiving_done", e.rcvd, got.rcvd);
         if (got.last !== e.last) report("last_of_run", e.last, got.last);
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic [1:0]            req_action = '0;
   logic [SEQ_W-1:0]      req_rx_seq = '0;
   logic [SEQ_W-1:0]      req_rx_ack = '0;
   logic                  req_rx_crc_ok = 1'b0;
   logic                  req_rx_final = 1'b0;
   logic [DATA_WIDTH-1:0] req_rx_data = '0;
   logic [DATA_WIDTH-1:0] req_tx_data = '0;
   logic                  req_tx_final = 1'b0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic [1:0]            rsp_out_kind;
   logic [SEQ_W-1:0]      rsp_out_seq;
   logic [SEQ_W-1:0]      rsp_out_ack;
   logic [DATA_WIDTH-1:0] rsp_out_data;
   logic                  rsp_out_end;
   logic                  rsp_sending_done;
   logic                  rsp_receiving_done;
   logic                  rsp_last_of_run;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [15:0]           csr_timeout_ticks = '0;

   arq_scoreboard sb = new();
   bit quiet = 0;

   go_back_n_arq_endpoint u_dut (.*);

   always #5 clock = ~clock;

   // result side: random pop stalls, checks every accepted beat
   initial begin
      rsp_type got;
      int  burst;
      bit  idle;
      burst = 0;
      idle = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            got.kind = rsp_out_kind;
            got.seq = rsp_out_seq;
            got.ack = rsp_out_ack;
            got.data = rsp_out_data;
            got.end_flag = rsp_out_end;
            got.sent = rsp_sending_done;
            got.rcvd = rsp_receiving_done;
            got.last = rsp_last_of_run;
            sb.check_rsp(got);
         end
         if (burst == 0) begin
            if (!quiet && $urandom_range(0, 9) < 3) begin
               idle = 1;
               burst = $urandom_range(1, 9);
            end else begin
               idle = 0;
               burst = $urandom_range(1, 20);
            end
         end
         burst--;
         rsp_pop <= !idle;
      end
   end

   // watchdog on cycles with no beat moving anywhere
   initial begin
      int stalled;
      stalled = 0;
      forever begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready))
            stalled = 0;
         else
            stalled++;
         if (stalled >= STALL_LIMIT) begin
            $display("go_back_n_arq_endpoint regression: fail");
            $finish;
         end
      end
   end

   task automatic send_beat(beat_type b);
      req_push <= 1'b1;
      req_action <= b.action;
      req_rx_seq <= b.rx_seq;
      req_rx_ack <= b.rx_ack;
      req_rx_crc_ok <= b.crc_ok;
      req_rx_final <= b.rx_final;
      req_rx_data <= b.rx_data;
      req_tx_data <= b.tx_data;
      req_tx_final <= b.tx_final;
      do @(posedge clock); while (req_full);
      sb.note_beat(b);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (sb.due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(bit [15:0] v);
      req_push <= 1'b0;
      wait_drained();
      csr_valid <= 1'b1;
      csr_timeout_ticks <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.timeout = v;
   endtask

   function automatic beat_type mk(bit [1:0] act, bit [2:0] seq, bit [2:0] ack, bit crc,
                                   bit fin, bit [31:0] data);
      beat_type b;
      b.action = act;
      b.rx_seq = seq;
      b.rx_ack = ack;
      b.crc_ok = crc;
      b.rx_final = fin;
      b.rx_data = data;
      b.tx_data = data;
      b.tx_final = fin;
      return b;
   endfunction

   function automatic beat_type rand_beat(bit allow_final);
      beat_type b;
      int r;
      r = $urandom_range(0, 99);
      b.action = (r < 40) ? ACT_RX : (r < 72) ? ACT_TX : (r < 95) ? ACT_TICK : ACT_UNUSED;
      b.rx_seq = 3'($urandom);
      b.rx_ack = 3'($urandom);
      b.rx_data = $urandom;
      b.tx_data = $urandom;
      b.crc_ok = ($urandom_range(0, 9) != 0);
      b.rx_final = allow_final && ($urandom_range(0, 29) == 0);
      b.tx_final = allow_final && ($urandom_range(0, 29) == 0);
      // mostly well-formed: in-order frames and acks inside the window
      if ($urandom_range(0, 99) < 85) begin
         if ($urandom_range(0, 3) != 0) b.rx_seq = sb.exp_seq;
         if (sb.in_flight != 0 && $urandom_range(0, 9) < 7)
            b.rx_ack = sb.oldest + 3'($urandom_range(0, sb.in_flight - 1));
      end
      return b;
   endfunction

   task automatic run_random(int n, bit allow_final);
      beat_type b;
      int i;
      i = 0;
      while (i < n) begin
         b = rand_beat(allow_final);
         send_beat(b);
         if (b.action != ACT_UNUSED) i++;
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      write_timeout(16'd1);

      // directed: idle ticks, noise, window fill, refusal, acks, timeouts
      send_beat(mk(ACT_TICK, 0, 0, 1, 0, 32'h0));
      send_beat(mk(ACT_UNUSED, 7, 7, 1, 1, 32'hffffffff));
      send_beat(mk(ACT_RX, 0, 0, 0, 0, 32'h12345678));
      send_beat(mk(ACT_TX, 0, 0, 1, 0, 32'h0));
      send_beat(mk(ACT_TX, 0, 0, 1, 0, 32'hffffffff));
      repeat (5) send_beat(mk(ACT_TX, 0, 0, 1, 0, $urandom));
      send_beat(mk(ACT_TX, 0, 0, 1, 0, 32'ha5a5a5a5));
      send_beat(mk(ACT_RX, 5, 7, 1, 0, $urandom));
      send_beat(mk(ACT_RX, 0, 1, 1, 0, 32'hffffffff));
      send_beat(mk(ACT_TICK, 0, 0, 1, 0, 32'h0));
      send_beat(mk(ACT_TICK, 0, 0, 1, 0, 32'h0));
      send_beat(mk(ACT_RX, 1, 6, 1, 0, 32'h0));
      send_beat(mk(ACT_TICK, 0, 0, 1, 0, 32'h0));
      send_beat(mk(ACT_TX, 0, 0, 1, 0, $urandom));
      send_beat(mk(ACT_TICK, 0, 0, 1, 0, 32'h0));
      send_beat(mk(ACT_TICK, 0, 0, 1, 0, 32'h0));
      send_beat(mk(ACT_RX, 7, sb.oldest, 1, 0, $urandom));

      write_timeout(16'd65535);
      run_random(60, 0);
      write_timeout(16'd3);
      run_random(60, 0);
      write_timeout(16'd2);
      run_random(60, 0);
      write_timeout(16'd1);
      quiet = 1;
      run_random(50, 1);

      // wind down: ack all, final payload, final frame, repeat, late payload, tick
      send_beat(mk(ACT_RX, sb.exp_seq + 3'd1, sb.send_seq - 3'd1, 1, 0, $urandom));
      send_beat(mk(ACT_TX, 0, 0, 1, 1, $urandom));
      send_beat(mk(ACT_RX, sb.exp_seq, sb.send_seq - 3'd1, 1, 1, $urandom));
      send_beat(mk(ACT_RX, sb.exp_seq, sb.send_seq - 3'd1, 1, 1, $urandom));
      send_beat(mk(ACT_TX, 0, 0, 1, 0, $urandom));
      send_beat(mk(ACT_TICK, 0, 0, 1, 0, 32'h0));

      req_push <= 1'b0;
      wait_drained();
      if (sb.errors == 0)
         $display("go_back_n_arq_endpoint regression: pass");
      else
         $display("go_back_n_arq_endpoint regression: fail");
      $finish;
   end

endmodule
